// ===== rtl/sepu_pkg.sv =====
// Package for the sonar echo pulse timer: field widths, register indexes,
// phase codes and the result word type. No dependencies.
package sepu_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned DIST_W          = 16;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned TIMEOUT_W       = 16;
  localparam int unsigned TRIG_W          = 8;
  localparam int unsigned HOLDOFF_W       = 16;
  localparam int unsigned CFG_DATA_W      = 16;
  localparam int unsigned CFG_IDX_W       = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF = 2'd2;

  // Register reset values
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd7885;
  localparam logic [TRIG_W-1:0]    TRIGGER_RST = 8'd2;
  localparam logic [HOLDOFF_W-1:0] HOLDOFF_RST = 16'd92;

  // Measurement phase codes
  localparam logic [1:0] PH_TRIGGER = 2'd0;
  localparam logic [1:0] PH_MEASURE = 2'd1;
  localparam logic [1:0] PH_HOLDOFF = 2'd2;

  typedef struct packed {
    logic              trigger_out;
    logic              measuring;
    logic [BYTE_W-1:0] spi_data;
    logic [DIST_W-1:0] distance_count;
    logic              done_pulse;
    logic              timed_out;
  } sepu_result_t;

endpackage

// ===== rtl/sepu_step.sv =====
// Per-tick phase sequencer and echo edge timing; one word updates the state
// in one pass. Depends on sepu_pkg.
module sepu_step
  import sepu_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  logic                 echo_level,
  input  logic                 spi_byte_done,
  input  logic [TIMEOUT_W-1:0] timeout_count,
  input  logic [TRIG_W-1:0]    trigger_ticks,
  input  logic [HOLDOFF_W-1:0] holdoff_ticks,
  output sepu_result_t         result
);

  localparam int unsigned CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  typedef logic [CMP_W-1:0]       cmp_t;
  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  localparam cnt_t CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [1:0]        phase_r, phase_nxt;
  cnt_t              tick_count_r, tick_count_nxt;
  cnt_t              rise_stamp_r, rise_stamp_nxt;
  logic              seen_rise_r, seen_rise_nxt;
  logic              prev_echo_r;
  logic [DIST_W-1:0] last_distance_r, last_distance_nxt;
  logic [BYTE_W-1:0] serial_byte_r, serial_byte_nxt;

  cnt_t              tick_inc;
  cnt_t              dist_raw;
  logic [TRIG_W-1:0] trig_len;
  logic              rise_hit;
  logic              seen_eff;
  cnt_t              stamp_eff;
  logic              fall_hit;
  logic              tmo_hit;
  logic              trig_end;
  logic              hold_end;

  // Saturating tick counter
  assign tick_inc  = (tick_count_r == CNT_MAX) ? CNT_MAX : tick_count_r + cnt_t'(1);
  assign trig_len  = (trigger_ticks == '0) ? TRIG_W'(1) : trigger_ticks;

  assign rise_hit  = !seen_rise_r && echo_level && !prev_echo_r;
  assign seen_eff  = seen_rise_r || rise_hit;
  assign stamp_eff = rise_hit ? tick_count_r : rise_stamp_r;
  assign fall_hit  = seen_eff && !echo_level && prev_echo_r;
  assign dist_raw  = tick_count_r - stamp_eff;

  assign tmo_hit   = (cmp_t'(tick_count_r) >= cmp_t'(timeout_count)) ||
                     (tick_count_r == CNT_MAX);
  assign trig_end  = (cmp_t'(tick_inc) >= cmp_t'(trig_len)) || (tick_inc == CNT_MAX);
  assign hold_end  = (cmp_t'(tick_inc) >= cmp_t'(holdoff_ticks)) ||
                     (tick_inc == CNT_MAX);

  always_comb begin
    phase_nxt         = phase_r;
    tick_count_nxt    = tick_count_r;
    rise_stamp_nxt    = rise_stamp_r;
    seen_rise_nxt     = seen_rise_r;
    last_distance_nxt = last_distance_r;
    serial_byte_nxt   = serial_byte_r;
    result            = '0;

    // A finished transfer shows the high byte; a completion below overrides it
    if (spi_byte_done) begin
      serial_byte_nxt = last_distance_r[DIST_W-1 -: BYTE_W];
    end

    case (phase_r)
      PH_MEASURE: begin
        result.measuring = 1'b1;
        rise_stamp_nxt   = stamp_eff;
        seen_rise_nxt    = seen_eff;
        if (fall_hit) begin
          last_distance_nxt = DIST_W'(dist_raw);
          serial_byte_nxt   = last_distance_nxt[BYTE_W-1:0];
          result.done_pulse = 1'b1;
        end else if (tmo_hit) begin
          last_distance_nxt = '0;
          serial_byte_nxt   = '0;
          result.done_pulse = 1'b1;
          result.timed_out  = 1'b1;
        end else begin
          tick_count_nxt = tick_inc;
        end
        if (result.done_pulse) begin
          seen_rise_nxt  = 1'b0;
          tick_count_nxt = '0;
          phase_nxt      = (holdoff_ticks == '0) ? PH_TRIGGER : PH_HOLDOFF;
        end
      end
      PH_HOLDOFF: begin
        tick_count_nxt = tick_inc;
        if (hold_end) begin
          tick_count_nxt = '0;
          phase_nxt      = PH_TRIGGER;
        end
      end
      default: begin
        // Trigger phase; the unused code behaves the same
        result.trigger_out = 1'b1;
        tick_count_nxt     = tick_inc;
        if (trig_end) begin
          tick_count_nxt = '0;
          rise_stamp_nxt = '0;
          seen_rise_nxt  = 1'b0;
          phase_nxt      = PH_MEASURE;
        end
      end
    endcase

    result.spi_data       = serial_byte_nxt;
    result.distance_count = last_distance_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_TRIGGER;
      tick_count_r    <= '0;
      rise_stamp_r    <= '0;
      seen_rise_r     <= 1'b0;
      prev_echo_r     <= 1'b0;
      last_distance_r <= '0;
      serial_byte_r   <= '0;
    end else if (step_en) begin
      phase_r         <= phase_nxt;
      tick_count_r    <= tick_count_nxt;
      rise_stamp_r    <= rise_stamp_nxt;
      seen_rise_r     <= seen_rise_nxt;
      prev_echo_r     <= echo_level;
      last_distance_r <= last_distance_nxt;
      serial_byte_r   <= serial_byte_nxt;
    end
  end

endmodule

// ===== rtl/sepu_skid.sv =====
// Two-entry result buffer: output register plus skid register, so the
// input stall is a registered signal. Depends on sepu_pkg.
module sepu_skid
  import sepu_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  sepu_result_t wr_data,
  output logic         full,
  output logic         out_valid,
  input  logic         out_stall,
  output sepu_result_t out_data
);

  logic         out_valid_r;
  logic         skid_valid_r;
  sepu_result_t out_data_r;
  sepu_result_t skid_data_r;
  logic         out_take;

  assign out_take  = out_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (wr_en) begin
      if (!out_valid_r || out_take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_data_r <= skid_data_r;
      end
    end else if (wr_en) begin
      if (!out_valid_r || out_take) begin
        out_data_r <= wr_data;
      end else begin
        skid_data_r <= wr_data;
      end
    end
  end

endmodule

// ===== rtl/sonar_echo_pulse_timer_unit.sv =====
// Sonar echo pulse timer top level: configuration registers, the per-tick
// sequencer and the result buffer. Depends on sepu_pkg, sepu_step, sepu_skid.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall   echo_level, spi_byte_done (one tick)
//   out_     output     out_valid/out_stall six result fields, one word per tick
//   cfg_     input      cfg_we              cfg_index, cfg_wdata
//
// Each input word is one timer tick: the sequencer state is updated in a single
// pass at the accepting edge and the result word lands in the result buffer on
// that same edge, so one word per cycle sustained while out_stall is low.
// Reset is synchronous on rst_n: trigger phase, counters cleared, registers at
// their defaults. A stall on the output fills the skid register; in_stall then
// rises (registered) and holds the input until the output drains.
module sonar_echo_pulse_timer_unit
  import sepu_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // tick input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_echo_level,
  input  logic                  in_spi_byte_done,
  // result output
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_trigger_out,
  output logic                  out_measuring,
  output logic [BYTE_W-1:0]     out_spi_data,
  output logic [DIST_W-1:0]     out_distance_count,
  output logic                  out_done_pulse,
  output logic                  out_timed_out,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [TIMEOUT_W-1:0] timeout_count_r;
  logic [TRIG_W-1:0]    trigger_ticks_r;
  logic [HOLDOFF_W-1:0] holdoff_ticks_r;

  logic         in_acc;
  logic         buf_full;
  sepu_result_t step_res;
  sepu_result_t out_res;

  assign in_acc   = in_valid && !buf_full;
  assign in_stall = buf_full;

  // Configuration registers; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_count_r <= TIMEOUT_RST;
      trigger_ticks_r <= TRIGGER_RST;
      holdoff_ticks_r <= HOLDOFF_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIMEOUT: timeout_count_r <= TIMEOUT_W'(cfg_wdata);
        CFG_TRIGGER: trigger_ticks_r <= cfg_wdata[TRIG_W-1:0];
        CFG_HOLDOFF: holdoff_ticks_r <= HOLDOFF_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Advance the sequencer once per accepted tick
  sepu_step #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_step (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (in_acc),
    .echo_level   (in_echo_level),
    .spi_byte_done(in_spi_byte_done),
    .timeout_count(timeout_count_r),
    .trigger_ticks(trigger_ticks_r),
    .holdoff_ticks(holdoff_ticks_r),
    .result       (step_res)
  );

  // Hold results until taken
  sepu_skid u_skid (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (in_acc),
    .wr_data  (step_res),
    .full     (buf_full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_res)
  );

  assign out_trigger_out    = out_res.trigger_out;
  assign out_measuring      = out_res.measuring;
  assign out_spi_data       = out_res.spi_data;
  assign out_distance_count = out_res.distance_count;
  assign out_done_pulse     = out_res.done_pulse;
  assign out_timed_out      = out_res.timed_out;

  // A timeout always ends a measurement tick
  a_timeout_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_timed_out) |-> (out_done_pulse && out_measuring))
    else $error("timeout word without done/measuring");

  // A word is never both trigger and measure
  a_phase_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_trigger_out && out_measuring))
    else $error("trigger and measuring together");

  // A word accepted against a blocked output must land in the skid register
  a_skid_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && out_valid && out_stall) |=> in_stall)
    else $error("skid register did not fill");

  // Timeout zeroes the reported distance
  a_timeout_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_timed_out) |-> (out_distance_count == '0 && out_spi_data == '0))
    else $error("timeout with nonzero distance");

endmodule
